FILE: rtl/c2dvw_pkg.sv
// ----------------------------------------------------------------------------
// c2dvw_pkg
// Shared types and constants of the valid-window 2D convolution unit.
// ----------------------------------------------------------------------------
package c2dvw_pkg;

  localparam int KMAX       = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int KW     = $clog2(KMAX + 1);            // kernel size width
  localparam int KIW    = $clog2(KMAX);                // kernel index width
  localparam int COLW   = $clog2(MAX_WIDTH);
  localparam int ROWW   = $clog2(MAX_HEIGHT);
  localparam int MASKAW = $clog2(KMAX * KMAX);
  localparam int LINEAW = $clog2(KMAX * MAX_WIDTH);
  localparam int SUMW   = 38;
  localparam int CFGW   = 11;

  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic               op;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUMW-1:0] window_sum;
    logic [9:0]             out_row;
    logic [9:0]             out_col;
    logic                   last_of_frame;
  } out_item_t;

endpackage

FILE: rtl/c2dvw_mac.sv
// ----------------------------------------------------------------------------
// c2dvw_mac
// Registered multiply and accumulate of one pixel and one coefficient.
// ----------------------------------------------------------------------------
module c2dvw_mac (
  input  logic                             clk,
  input  logic                             start,
  input  logic                             en,
  input  logic signed [15:0]               pix,
  input  logic signed [15:0]               coef,
  output logic signed [c2dvw_pkg::SUMW-1:0] acc
);
  import c2dvw_pkg::*;

  logic signed [31:0] prod;
  logic               prod_vld;
  logic               prod_first;

  always_ff @(posedge clk) begin
    prod       <= pix * coef;
    prod_vld   <= en;
    prod_first <= start;
    if (prod_vld) begin
      if (prod_first) begin
        acc <= SUMW'(prod);
      end else begin
        acc <= acc + SUMW'(prod);
      end
    end
  end

endmodule

FILE: rtl/conv2d_valid_window_unit.sv
// ----------------------------------------------------------------------------
// conv2d_valid_window_unit
// Valid-region k x k sliding-window sum of products over a raster image.
// ----------------------------------------------------------------------------
// A coefficient transfer, and a pixel transfer that yields no result, pass
// through S_WRITE and back to S_IDLE. One that yields a result then walks
// the k*k window taps in S_TAPS, because every window tap is fetched from
// the line memory and the mask memory one per cycle and passes through a
// single multiplier. After the taps come S_DRAIN1, S_DRAIN2 and S_DRAIN3,
// which carry the last tap through the memory read, the multiply and the
// accumulate. The result sits in an output register, so the next input transfer can be taken while it waits.
// No clearing pass is needed for the line memory: it is only read at
// positions of the current frame that have already been written. The mask
// memory keeps one written flag per entry. These flags are cleared at reset,
// so a coefficient that has never been written reads as zero.
module conv2d_valid_window_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  c2dvw_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output c2dvw_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [10:0]           cfg_data
);
  import c2dvw_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_TAPS, S_DRAIN1, S_DRAIN2, S_DRAIN3,
                            S_HOLD} state_t;

  state_t state;

  // Registers and clamped values.
  logic [3:0]        kernel_size;
  logic [CFGW-1:0]   image_width, image_height;
  logic [KW-1:0]     k;
  logic [COLW:0]     w;
  logic [ROWW:0]     h;

  always_comb begin
    if (kernel_size == 4'd0) k = KW'(1);
    else if (kernel_size > 4'(KMAX)) k = KW'(KMAX);
    else k = KW'(kernel_size);
    if (image_width == '0) w = (COLW+1)'(1);
    else if (image_width > CFGW'(MAX_WIDTH)) w = (COLW+1)'(MAX_WIDTH);
    else w = (COLW+1)'(image_width);
    if (image_height == '0) h = (ROWW+1)'(1);
    else if (image_height > CFGW'(MAX_HEIGHT)) h = (ROWW+1)'(MAX_HEIGHT);
    else h = (ROWW+1)'(image_height);
  end

  // Memories.
  logic signed [15:0] mask_mem [KMAX*KMAX];
  logic signed [15:0] line_mem [KMAX*MAX_WIDTH];
  logic signed [15:0] mask_rd, line_rd;
  logic               mask_we, line_we;
  logic [MASKAW-1:0]  mask_wa, mask_ra;
  logic [LINEAW-1:0]  line_wa, line_ra;
  logic signed [15:0] mask_wd, line_wd;
  logic [KMAX*KMAX-1:0] mask_set;
  logic               mask_hit;
  logic signed [15:0] mask_tap;

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_wa] <= mask_wd;
    mask_rd <= mask_mem[mask_ra];
  end

  // Written flags of the mask entries; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_set <= '0;
    end else if (mask_we) begin
      mask_set[mask_wa] <= 1'b1;
    end
    mask_hit <= mask_set[mask_ra];
  end

  assign mask_tap = mask_hit ? mask_rd : 16'sd0;

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    line_rd <= line_mem[line_ra];
  end

  // Captured transfer and position.
  in_item_t          item;
  logic [ROWW:0]     row_count;
  logic [COLW:0]     col_count;
  logic [ROWW:0]     r;
  logic [COLW:0]     c;
  logic [KIW-1:0]    ki, kj;
  logic [ROWW-1:0]   r0;
  logic [COLW-1:0]   c0;
  logic              last;
  logic              mac_en, mac_start;
  logic signed [SUMW-1:0] acc;
  logic              fires;
  logic [ROWW:0]     tap_row;
  logic [COLW:0]     tap_col;

  always_comb begin
    if (row_count >= h || col_count >= w) begin
      r = '0;
      c = '0;
    end else begin
      r = row_count;
      c = col_count;
    end
    fires = ((COLW+1)'(k) <= w) && ((ROWW+1)'(k) <= h) &&
            (r + 1'b1 >= (ROWW+1)'(k)) && (c + 1'b1 >= (COLW+1)'(k));
    tap_row = (ROWW+1)'(r0) + (ROWW+1)'(ki);
    tap_col = (COLW+1)'(c0) + (COLW+1)'(kj);
    mask_ra = MASKAW'(ki) * MASKAW'(k) + MASKAW'(kj);
    line_ra = {tap_row[KIW-1:0], tap_col[COLW-1:0]};
    mask_we = (state == S_WRITE) && (item.op == OP_COEF) &&
              (item.coef_index < 7'(KMAX * KMAX));
    mask_wa = MASKAW'(item.coef_index);
    mask_wd = item.coef_value;
    line_we = (state == S_WRITE) && (item.op == OP_PIXEL);
    line_wa = {r[KIW-1:0], c[COLW-1:0]};
    line_wd = item.pixel_value;
  end

  assign in_stall = !(state == S_IDLE || (state == S_HOLD && !out_stall));

  logic tap_vld, tap_first;
  logic is_first_tap, is_last_tap;
  assign is_first_tap = (ki == '0) && (kj == '0);
  assign is_last_tap  = (KW'(ki) == k - 1'b1) && (KW'(kj) == k - 1'b1);

  always_ff @(posedge clk) begin
    tap_vld   <= (state == S_TAPS);
    tap_first <= (state == S_TAPS) && is_first_tap;
  end

  assign mac_en    = tap_vld;
  assign mac_start = tap_first;

  c2dvw_mac u_mac (
    .clk   (clk),
    .start (mac_start),
    .en    (mac_en),
    .pix   (line_rd),
    .coef  (mask_tap),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kernel_size  <= 4'd3;
      image_width  <= CFGW'(64);
      image_height <= CFGW'(64);
      row_count    <= '0;
      col_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_DRAIN3 && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL_SIZE:  kernel_size  <= cfg_data[3:0];
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_IMAGE_HEIGHT) begin
          row_count <= '0;
          col_count <= '0;
        end
      end
      case (state)
        S_IDLE, S_HOLD: begin
          if (state == S_HOLD && !out_stall) state <= S_IDLE;
          if (in_valid && !in_stall) begin
            item  <= in_data;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
          if (item.op == OP_PIXEL) begin
            r0   <= ROWW'(r + 1'b1 - (ROWW+1)'(k));
            c0   <= COLW'(c + 1'b1 - (COLW+1)'(k));
            last <= (r == h - 1'b1) && (c == w - 1'b1);
            ki   <= '0;
            kj   <= '0;
            if (fires) state <= S_TAPS;
            if (c + 1'b1 >= w) begin
              col_count <= '0;
              row_count <= (r + 1'b1 >= h) ? '0 : r + 1'b1;
            end else begin
              col_count <= c + 1'b1;
              row_count <= r;
            end
          end
        end
        S_TAPS: begin
          if (is_last_tap) begin
            state <= S_DRAIN1;
          end else if (KW'(kj) == k - 1'b1) begin
            kj <= '0;
            ki <= ki + 1'b1;
          end else begin
            kj <= kj + 1'b1;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        // The last product is added into the accumulator at the end of this cycle.
        S_DRAIN2: state <= S_DRAIN3;
        S_DRAIN3: begin
          if (!out_valid || !out_stall) begin
            out_data.window_sum    <= acc;
            out_data.out_row       <= 10'(r0);
            out_data.out_col       <= 10'(c0);
            out_data.last_of_frame <= last;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAPS) |-> in_stall) else $error("accept during taps");
  a_taps_pixel: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAPS) |-> (item.op == OP_PIXEL)) else $error("taps for coef");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule
